// File: hdl/pcr_pkg.sv
// Package for the phone context rewriter: beat and state types, action codes,
// the fixed next-state table and the vowel hash codes.
// Used by pcr_decode and phone_context_rewriter_top; depends on nothing.
package pcr_pkg;

  localparam int unsigned NUM_CATS   = 18;
  localparam int unsigned NUM_STATES = 19;
  localparam int unsigned NUM_VOWELS = 13;
  localparam int unsigned ROW_W      = 26;
  localparam int unsigned PAIR_W     = 2 * ROW_W;
  localparam int unsigned NUM_PAIRS  = 6;

  // Configuration register indexes.
  localparam logic [2:0] CFG_IDX_ROW12 = 3'd6;

  // Rule states that decode to an action, and the idle state.
  localparam logic [4:0] ST_STOP_A = 5'd2;
  localparam logic [4:0] ST_STOP_B = 5'd4;
  localparam logic [4:0] ST_L      = 5'd6;
  localparam logic [4:0] ST_VOWEL  = 5'd8;
  localparam logic [4:0] ST_QC_A   = 5'd10;
  localparam logic [4:0] ST_STOP_C = 5'd11;
  localparam logic [4:0] ST_QC_B   = 5'd12;
  localparam logic [4:0] ST_QS     = 5'd14;
  localparam logic [4:0] ST_QZ     = 5'd16;
  localparam logic [4:0] ST_LL     = 5'd18;
  localparam logic [4:0] ST_IDLE   = 5'd0;

  // Vowel table actions.
  localparam logic [1:0] VACT_GLOTTAL = 2'd1;
  localparam logic [1:0] VACT_R       = 2'd2;

  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_D    = 8'h64;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_P    = 8'h70;
  localparam logic [7:0] CH_B    = 8'h62;
  localparam logic [7:0] CH_K    = 8'h6b;
  localparam logic [7:0] CH_G    = 8'h67;

  typedef enum logic [3:0] {
    ACT_NONE = 4'd0,
    ACT_QT   = 4'd1,
    ACT_QP   = 4'd2,
    ACT_QK   = 4'd3,
    ACT_QC   = 4'd4,
    ACT_QS   = 4'd5,
    ACT_QZ   = 4'd6,
    ACT_GS   = 4'd7,
    ACT_R    = 4'd8,
    ACT_L    = 4'd9,
    ACT_LP   = 4'd10,
    ACT_LL   = 4'd11,
    ACT_LLP  = 4'd12
  } action_t;

  typedef struct packed {
    logic [4:0] category_index;
    logic [7:0] first_char;
    logic [7:0] second_char;
    logic       has_prime;
    logic       word_marker;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] first_char;
    logic [7:0] second_char;
  } prev_t;

  typedef struct packed {
    action_t    action_code;
    logic [4:0] new_state;
    prev_t      prev;
  } result_t;

  typedef logic [NUM_VOWELS-1:0][ROW_W-1:0] vrows_t;

  localparam logic [8:0] VOWEL_CODE [NUM_VOWELS] = '{
    9'd194, 9'd201, 9'd97, 9'd101, 9'd105, 9'd111, 9'd221,
    9'd117, 9'd211, 9'd216, 9'd202, 9'd215, 9'd234
  };

  localparam logic [4:0] NEXT_TAB [NUM_STATES][NUM_CATS] = '{
    '{5'd1, 5'd9, 5'd0, 5'd7, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd0, 5'd0, 5'd0, 5'd17},
    '{5'd3, 5'd9, 5'd0, 5'd7, 5'd2, 5'd2, 5'd2, 5'd2, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd0, 5'd0, 5'd0, 5'd17},
    '{5'd1, 5'd9, 5'd0, 5'd7, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd0, 5'd0, 5'd0, 5'd17},
    '{5'd4, 5'd9, 5'd0, 5'd7, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd0, 5'd0, 5'd0, 5'd17},
    '{5'd1, 5'd9, 5'd0, 5'd7, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd0, 5'd0, 5'd0, 5'd17},
    '{5'd1, 5'd9, 5'd0, 5'd6, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd0, 5'd0, 5'd0, 5'd17},
    '{5'd1, 5'd9, 5'd0, 5'd8, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd0, 5'd0, 5'd0, 5'd17},
    '{5'd1, 5'd9, 5'd0, 5'd8, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd0, 5'd0, 5'd0, 5'd17},
    '{5'd1, 5'd9, 5'd0, 5'd8, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd0, 5'd0, 5'd0, 5'd17},
    '{5'd10, 5'd12, 5'd12, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd0, 5'd0, 5'd0, 5'd17},
    '{5'd11, 5'd11, 5'd11, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd0, 5'd0, 5'd0, 5'd17},
    '{5'd1, 5'd9, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd0, 5'd0, 5'd0, 5'd17},
    '{5'd1, 5'd9, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd0, 5'd0, 5'd0, 5'd17},
    '{5'd1, 5'd9, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd14, 5'd0, 5'd0, 5'd17},
    '{5'd1, 5'd9, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd0, 5'd0, 5'd0, 5'd17},
    '{5'd1, 5'd9, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd16, 5'd0, 5'd0, 5'd17},
    '{5'd1, 5'd9, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd0, 5'd0, 5'd0, 5'd17},
    '{5'd1, 5'd9, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd0, 5'd0, 5'd18, 5'd17},
    '{5'd1, 5'd9, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd5,
      5'd13, 5'd13, 5'd15, 5'd15, 5'd0, 5'd0, 5'd0, 5'd17}
  };

endpackage

// File: hdl/pcr_decode.sv
// Combinational decode of one phone beat: next rule state, action code and
// the previous-phone record that follows. Depends on pcr_pkg.
module pcr_decode (
  input  pcr_pkg::item_t   item,
  input  logic [4:0]       rule_state,
  input  pcr_pkg::prev_t   prev,
  input  pcr_pkg::vrows_t  vrows,
  output pcr_pkg::result_t res
);

  function automatic logic [3:0] vowel_index(input logic [7:0] c0, input logic [7:0] c1);
    logic [8:0] h;
    logic [3:0] idx;
    h   = {1'b0, c0} + ((c1 == pcr_pkg::CH_APOS) ? 9'd0 : {1'b0, c1});
    idx = 4'(pcr_pkg::NUM_VOWELS);
    for (int i = pcr_pkg::NUM_VOWELS - 1; i >= 0; i--) begin
      if (h == pcr_pkg::VOWEL_CODE[i]) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

  logic [7:0]            p0;
  logic [7:0]            p1;
  logic [3:0]            row_idx;
  logic [3:0]            col_idx;
  logic [pcr_pkg::ROW_W-1:0] row;
  logic [1:0]            vact;
  pcr_pkg::action_t      vowel_act;
  pcr_pkg::action_t      stop_act;
  pcr_pkg::action_t      act;
  logic [4:0]            st;
  logic                  matched;

  assign p0 = prev.valid ? prev.first_char : 8'd0;
  assign p1 = prev.valid ? prev.second_char : 8'd0;

  assign row_idx = vowel_index(p0, p1);
  assign col_idx = vowel_index(item.first_char, item.second_char);

  always_comb begin
    row  = '0;
    vact = 2'd0;
    if (row_idx < 4'(pcr_pkg::NUM_VOWELS) && col_idx < 4'(pcr_pkg::NUM_VOWELS)) begin
      row  = vrows[row_idx];
      vact = row[{col_idx, 1'b0} +: 2];
    end
    if (vact == pcr_pkg::VACT_GLOTTAL) begin
      vowel_act = pcr_pkg::ACT_GS;
    end else if (vact == pcr_pkg::VACT_R) begin
      vowel_act = pcr_pkg::ACT_R;
    end else begin
      vowel_act = pcr_pkg::ACT_NONE;
    end
  end

  always_comb begin
    priority if (p0 == pcr_pkg::CH_D || p0 == pcr_pkg::CH_T) begin
      stop_act = pcr_pkg::ACT_QT;
    end else if (p0 == pcr_pkg::CH_P || p0 == pcr_pkg::CH_B) begin
      stop_act = pcr_pkg::ACT_QP;
    end else if (p0 == pcr_pkg::CH_K || p0 == pcr_pkg::CH_G) begin
      stop_act = pcr_pkg::ACT_QK;
    end else begin
      stop_act = pcr_pkg::ACT_NONE;
    end
  end

  assign matched = item.category_index < 5'(pcr_pkg::NUM_CATS);

  always_comb begin
    st = pcr_pkg::ST_IDLE;
    if (matched && rule_state < 5'(pcr_pkg::NUM_STATES)) begin
      st = pcr_pkg::NEXT_TAB[rule_state][item.category_index];
    end else if (matched) begin
      st = pcr_pkg::NEXT_TAB[0][item.category_index];
    end
  end

  always_comb begin
    unique case (st)
      pcr_pkg::ST_STOP_A, pcr_pkg::ST_STOP_B, pcr_pkg::ST_STOP_C: act = stop_act;
      pcr_pkg::ST_L:     act = item.has_prime ? pcr_pkg::ACT_LP : pcr_pkg::ACT_L;
      pcr_pkg::ST_VOWEL: act = item.word_marker ? vowel_act : pcr_pkg::ACT_NONE;
      pcr_pkg::ST_QC_A, pcr_pkg::ST_QC_B: act = pcr_pkg::ACT_QC;
      pcr_pkg::ST_QS:    act = pcr_pkg::ACT_QS;
      pcr_pkg::ST_QZ:    act = pcr_pkg::ACT_QZ;
      pcr_pkg::ST_LL: begin
        if (!item.word_marker) begin
          act = pcr_pkg::ACT_NONE;
        end else begin
          act = item.has_prime ? pcr_pkg::ACT_LLP : pcr_pkg::ACT_LL;
        end
      end
      default:           act = pcr_pkg::ACT_NONE;
    endcase
  end

  always_comb begin
    if (matched) begin
      res.action_code      = act;
      res.new_state        = st;
      res.prev.valid       = 1'b1;
      res.prev.first_char  = item.first_char;
      res.prev.second_char = item.second_char;
    end else begin
      res.action_code      = pcr_pkg::ACT_NONE;
      res.new_state        = pcr_pkg::ST_IDLE;
      res.prev             = '0;
    end
  end

endmodule

// File: hdl/phone_context_rewriter_top.sv
// Top level of the phone context rewriter: input register, result register,
// rule state, previous phone and the vowel table registers.
// Depends on pcr_pkg and pcr_decode.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, in_<field>          | phone beats in
//   out     | out_valid, out_stall, out_<field>       | result beats out
//   cfg     | cfg_we, cfg_index, cfg_data             | vowel table writes
//
// A beat is held in the input register and then moves to the result
// register, which presents its result. One beat per cycle is sustained
// while the output is not stalled; the rule state updates as a beat enters
// the result register, so the next beat sees it at once.
// A stall on the output holds both registers and raises in_stall when full.
// Reset clears the rule state, the previous phone and all table registers.
module phone_context_rewriter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_category_index,
  input  logic [7:0]  in_first_char,
  input  logic [7:0]  in_second_char,
  input  logic        in_has_prime,
  input  logic        in_word_marker,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_action_code,
  output logic [4:0]  out_new_state,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [pcr_pkg::PAIR_W-1:0] cfg_data
);

  logic                       s1_valid_r;
  pcr_pkg::item_t             s1_item_r;
  logic                       out_valid_r;
  logic [3:0]                 out_action_r;
  logic [4:0]                 out_state_r;
  logic [4:0]                 rule_state_r;
  pcr_pkg::prev_t             prev_r;
  logic [pcr_pkg::NUM_PAIRS-1:0][pcr_pkg::PAIR_W-1:0] pairs_r;
  logic [pcr_pkg::ROW_W-1:0]  row12_r;
  pcr_pkg::vrows_t            vrows;
  pcr_pkg::result_t           res;
  logic                       adv;
  logic                       in_acc;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    for (int k = 0; k < pcr_pkg::NUM_PAIRS; k++) begin
      vrows[2*k]     = pairs_r[k][pcr_pkg::ROW_W-1:0];
      vrows[2*k + 1] = pairs_r[k][pcr_pkg::PAIR_W-1:pcr_pkg::ROW_W];
    end
    vrows[pcr_pkg::NUM_VOWELS-1] = row12_r;
  end

  pcr_decode u_decode (
    .item       (s1_item_r),
    .rule_state (rule_state_r),
    .prev       (prev_r),
    .vrows      (vrows),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      rule_state_r <= '0;
      prev_r       <= '0;
      pairs_r      <= '0;
      row12_r      <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r  <= 1'b1;
        rule_state_r <= res.new_state;
        prev_r       <= res.prev;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == pcr_pkg::CFG_IDX_ROW12) begin
          row12_r <= cfg_data[pcr_pkg::ROW_W-1:0];
        end else if (cfg_index < pcr_pkg::CFG_IDX_ROW12) begin
          pairs_r[cfg_index] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.category_index <= in_category_index;
      s1_item_r.first_char     <= in_first_char;
      s1_item_r.second_char    <= in_second_char;
      s1_item_r.has_prime      <= in_has_prime;
      s1_item_r.word_marker    <= in_word_marker;
    end
    if (adv) begin
      out_action_r <= res.action_code;
      out_state_r  <= res.new_state;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action_code = out_action_r;
  assign out_new_state   = out_state_r;

endmodule
